// ===== sv/gasa_pkg.sv =====
// Shared types and constants for the glyph atlas shelf allocator.
package gasa_pkg;

	// Table of placed glyphs
	localparam int TABLE_DEPTH = 1024;
	localparam int TABLE_AW    = $clog2(TABLE_DEPTH);
	localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);

	// Configuration register indexes
	localparam logic [1:0] REG_TEXTURE_WIDTH  = 2'd0;
	localparam logic [1:0] REG_TEXTURE_HEIGHT = 2'd1;
	localparam logic [1:0] REG_GLYPH_GAP      = 2'd2;

	// Result status codes
	localparam logic [1:0] STATUS_FOUND     = 2'd0;
	localparam logic [1:0] STATUS_PLACED    = 2'd1;
	localparam logic [1:0] STATUS_FULL      = 2'd2;
	localparam logic [1:0] STATUS_EXHAUSTED = 2'd3;

	// Request item
	typedef struct packed {
		logic        [20:0] code_point;
		logic        [7:0]  font_id;
		logic signed [15:0] offset_x;
		logic signed [15:0] offset_y;
		logic        [7:0]  box_width;
		logic        [7:0]  box_height;
		logic        [7:0]  border_width;
		logic        [7:0]  border_alpha;
	} req_t;

	// Result item
	typedef struct packed {
		logic        [15:0] page_index;
		logic        [15:0] pos_x;
		logic        [15:0] pos_y;
		logic signed [15:0] stored_offset_x;
		logic signed [15:0] stored_offset_y;
		logic        [7:0]  stored_height;
		logic        [1:0]  status;
	} rsp_t;

endpackage

// ===== sv/glyph_atlas_shelf_allocator.sv =====
// Glyph atlas shelf allocator: key lookup over the placed-glyph table and shelf placement.
//
// One request item at a time. The placed-glyph table is scanned through its single read
// port, one entry per clock, stopping early on a hit. A hit then goes to the output
// register; a new key first takes the placement arithmetic (row wrap, then page check and
// table write), and a new key on a full table goes straight to the output register.
// req_stall is high from acceptance until the result has moved to the output register; the
// output register lets the next request enter while a result still waits on rsp_stall. The
// table is not cleared at reset: only entries below the fill count are ever read.
// The user must write the configuration registers through cfg_we / cfg_index / cfg_wdata
// only while no request is in work; the block itself does not enforce it.
module glyph_atlas_shelf_allocator (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  gasa_pkg::req_t      req,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output gasa_pkg::rsp_t      rsp,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [15:0]         cfg_wdata
);
	import gasa_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_SCAN  = 5'b00010,
		S_WRAP  = 5'b00100,
		S_PLACE = 5'b01000,
		S_DONE  = 5'b10000
	} state_t;

	typedef struct packed {
		logic [7:0]  height;
		logic [15:0] pos_y;
		logic [15:0] pos_x;
		logic [15:0] page;
	} place_t;

	// Table storage
	logic [44:0] key_mem   [TABLE_DEPTH];
	place_t      place_mem [TABLE_DEPTH];
	logic [31:0] offs_mem  [TABLE_DEPTH];

	state_t state_q;

	// Configuration
	logic [15:0] tex_w_q, tex_h_q, glyph_gap_q;

	// Packing state
	logic [15:0]        cur_x_q, cur_y_q, row_h_q;
	logic [16:0]        pages_q;
	logic [COUNT_W-1:0] count_q;

	// Request in work
	logic [44:0]        key_q;
	logic signed [15:0] ox_q, oy_q;
	logic [7:0]         bw_q, bh_q;
	logic [15:0]        gap_q;

	// Scan
	logic [COUNT_W-1:0] rd_idx_q;
	logic               pend_s1;
	logic [44:0]        rd_key_s1;
	place_t             rd_place_s1;
	logic [31:0]        rd_offs_s1;
	logic               issue, hit, miss, full;

	// Placement
	logic [15:0] wcx_q, wcy_q, wrh_q;
	logic [17:0] sum_x, sum_y;
	logic        wrap, new_page, exhausted;
	logic [15:0] w_cx, w_cy, w_rh;
	logic [16:0] p_pages;
	logic [15:0] p_cx0, p_cy0, p_cx, p_cy, p_rh, p_page, p_rh_max;
	place_t      p_place;
	logic        mem_we;

	// Result and output register
	rsp_t res_q, rsp_q;
	logic rsp_valid_q;
	logic accept, out_free;

	assign req_stall = (state_q != S_IDLE);
	assign accept    = req_valid && !req_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign out_free  = !rsp_valid_q || !rsp_stall;

	// Scan control: one read per cycle, compare the entry read on the previous cycle
	assign issue = (state_q == S_SCAN) && (rd_idx_q != count_q);
	assign hit   = pend_s1 && (rd_key_s1 == key_q);
	assign miss  = !pend_s1 && (rd_idx_q == count_q);
	assign full  = (count_q == COUNT_W'(TABLE_DEPTH));

	// Row wrap
	always_comb begin
		sum_x = 18'(cur_x_q) + 18'(bw_q) + 18'(gap_q);
		wrap  = (pages_q != 17'd0) && (sum_x >= 18'(tex_w_q));
		w_cx  = wrap ? gap_q : cur_x_q;
		w_cy  = wrap ? 16'(cur_y_q + row_h_q + gap_q + 16'd1) : cur_y_q;
		w_rh  = wrap ? 16'd0 : row_h_q;
	end

	// Page check, clamp to gap, placement record
	always_comb begin
		sum_y     = 18'(wcy_q) + 18'(bh_q) + 18'(gap_q) + 18'd1;
		new_page  = (pages_q == 17'd0) || (sum_y >= 18'(tex_h_q));
		exhausted = new_page && pages_q[16];
		p_pages   = new_page ? pages_q + 17'd1 : pages_q;
		p_cx0     = new_page ? glyph_gap_q : wcx_q;
		p_cy0     = new_page ? glyph_gap_q : wcy_q;
		p_rh      = new_page ? 16'd0 : wrh_q;
		p_cx      = (p_cx0 < gap_q) ? gap_q : p_cx0;
		p_cy      = (p_cy0 < gap_q) ? gap_q : p_cy0;
		p_page    = p_pages[15:0] - 16'd1;
		p_rh_max  = (p_rh > 16'(bh_q)) ? p_rh : 16'(bh_q);
		p_place   = '{height: bh_q, pos_y: p_cy, pos_x: p_cx, page: p_page};
		mem_we    = (state_q == S_PLACE) && !exhausted;
	end

	// Table write and registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			key_mem[count_q[TABLE_AW-1:0]]   <= key_q;
			place_mem[count_q[TABLE_AW-1:0]] <= p_place;
			offs_mem[count_q[TABLE_AW-1:0]]  <= {oy_q, ox_q};
		end
		if (issue) begin
			rd_key_s1   <= key_mem[rd_idx_q[TABLE_AW-1:0]];
			rd_place_s1 <= place_mem[rd_idx_q[TABLE_AW-1:0]];
			rd_offs_s1  <= offs_mem[rd_idx_q[TABLE_AW-1:0]];
		end
	end

	// Request capture and placement working registers
	always_ff @(posedge clk) begin
		if (accept) begin
			key_q <= {req.border_alpha, req.border_width, req.font_id, req.code_point};
			ox_q  <= req.offset_x;
			oy_q  <= req.offset_y;
			bw_q  <= req.box_width;
			bh_q  <= req.box_height;
			gap_q <= glyph_gap_q + 16'(req.border_width);
		end
		if (state_q == S_WRAP) begin
			wcx_q <= w_cx;
			wcy_q <= w_cy;
			wrh_q <= w_rh;
		end
		if (state_q == S_SCAN && hit) begin
			res_q <= '{page_index: rd_place_s1.page, pos_x: rd_place_s1.pos_x,
				pos_y: rd_place_s1.pos_y, stored_offset_x: rd_offs_s1[15:0],
				stored_offset_y: rd_offs_s1[31:16], stored_height: rd_place_s1.height,
				status: STATUS_FOUND};
		end else if (state_q == S_SCAN && miss && full) begin
			res_q <= '{status: STATUS_FULL, default: '0};
		end else if (state_q == S_PLACE) begin
			if (exhausted) begin
				res_q <= '{status: STATUS_EXHAUSTED, default: '0};
			end else begin
				res_q <= '{page_index: p_page, pos_x: p_cx, pos_y: p_cy,
					stored_offset_x: ox_q, stored_offset_y: oy_q, stored_height: bh_q,
					status: STATUS_PLACED};
			end
		end
		if (state_q == S_DONE && out_free) begin
			rsp_q <= res_q;
		end
	end

	// Sequencer, packing state, configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			tex_w_q     <= 16'd1024;
			tex_h_q     <= 16'd1024;
			glyph_gap_q <= 16'd1;
			cur_x_q     <= '0;
			cur_y_q     <= '0;
			row_h_q     <= '0;
			pages_q     <= '0;
			count_q     <= '0;
			rd_idx_q    <= '0;
			pend_s1     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			// Configuration writes
			if (cfg_we) begin
				unique case (cfg_index)
					REG_TEXTURE_WIDTH:  tex_w_q     <= cfg_wdata;
					REG_TEXTURE_HEIGHT: tex_h_q     <= cfg_wdata;
					REG_GLYPH_GAP:      glyph_gap_q <= cfg_wdata;
					default: ;
				endcase
			end

			pend_s1 <= issue;
			if (issue) begin
				rd_idx_q <= rd_idx_q + COUNT_W'(1);
			end

			// Load a finished result, else drop a delivered one
			if (state_q == S_DONE && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						rd_idx_q <= '0;
						state_q  <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (hit) begin
						state_q <= S_DONE;
					end else if (miss) begin
						state_q <= full ? S_DONE : S_WRAP;
					end
				end
				S_WRAP: begin
					state_q <= S_PLACE;
				end
				S_PLACE: begin
					if (!exhausted) begin
						count_q <= count_q + COUNT_W'(1);
						cur_x_q <= p_cx + 16'(bw_q) + glyph_gap_q;
						cur_y_q <= p_cy;
						row_h_q <= p_rh_max;
						pages_q <= p_pages;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== sim/glyph_atlas_shelf_allocator_test.sv =====
// Self-checking testbench for the glyph atlas shelf allocator: random and directed requests.
`timescale 1ns / 1ps

module glyph_atlas_shelf_allocator_test;
	import gasa_pkg::*;

	localparam int unsigned CYCLE_LIMIT    = 5_000_000;
	localparam int unsigned MAX_PAGES      = 65536;
	localparam int unsigned CODE_POINT_MAX = 1114111;
	localparam int unsigned PHASE_ITEMS    = 94;
	localparam int unsigned HOLD_AFTER     = 150;
	localparam int unsigned HOLD_CYCLES    = 2000;

	typedef enum int {KEY_FRESH, KEY_REPEAT, KEY_NEAR} key_kind_t;

	// Shelf placement predictor and the queue of placements it expects back
	class placement_scoreboard;
		int unsigned tex_w, tex_h, spacing;
		int unsigned cursor_x, cursor_y, row_h, pages_open, fill;
		logic [44:0] placed_keys [TABLE_DEPTH];
		rsp_t        placed_results [TABLE_DEPTH];
		rsp_t        expected_placements [$];
		int unsigned errors, results_checked;

		function new();
			tex_w = 1024;
			tex_h = 1024;
			spacing = 1;
			cursor_x = 0;
			cursor_y = 0;
			row_h = 0;
			pages_open = 0;
			fill = 0;
			errors = 0;
			results_checked = 0;
		endfunction

		function void configure(int unsigned w, int unsigned h, int unsigned g);
			tex_w = w;
			tex_h = h;
			spacing = g;
		endfunction

		function void note_request(req_t r);
			rsp_t        e;
			logic [44:0] k;
			int unsigned gap, cx, cy, rh, pg;
			bit          fresh, hit;
			e = '0;
			hit = 1'b0;
			k = {r.border_alpha, r.border_width, r.font_id, r.code_point};
			// look the key up among placed glyphs
			for (int unsigned i = 0; i < fill; i++) begin
				if (!hit && placed_keys[i] == k) begin
					e = placed_results[i];
					e.status = STATUS_FOUND;
					hit = 1'b1;
				end
			end
			if (!hit && fill >= TABLE_DEPTH) begin
				e.status = STATUS_FULL;
			end else if (!hit) begin
				gap = (spacing + r.border_width) & 32'hFFFF;
				cx = cursor_x;
				cy = cursor_y;
				rh = row_h;
				pg = pages_open;
				fresh = (pg == 0);
				// wrap the row, then check the page height
				if (!fresh) begin
					if (cx + r.box_width + gap >= tex_w) begin
						cx = gap;
						cy = (cy + rh + gap + 1) & 32'hFFFF;
						rh = 0;
					end
					if (cy + r.box_height + gap + 1 >= tex_h)
						fresh = 1'b1;
				end
				if (fresh && pg >= MAX_PAGES) begin
					e.status = STATUS_EXHAUSTED;
				end else begin
					if (fresh) begin
						pg++;
						cx = spacing;
						cy = spacing;
						rh = 0;
					end
					if (cx < gap) cx = gap;
					if (cy < gap) cy = gap;
					e.page_index = 16'(pg - 1);
					e.pos_x = 16'(cx);
					e.pos_y = 16'(cy);
					e.stored_offset_x = r.offset_x;
					e.stored_offset_y = r.offset_y;
					e.stored_height = r.box_height;
					e.status = STATUS_PLACED;
					placed_keys[fill] = k;
					placed_results[fill] = e;
					fill++;
					cursor_x = (cx + r.box_width + spacing) & 32'hFFFF;
					cursor_y = cy;
					row_h = (rh > r.box_height) ? rh : r.box_height;
					pages_open = pg;
				end
			end
			expected_placements.push_back(e);
		endfunction

		function void report_field(string name, logic [15:0] want, logic [15:0] got);
			if (want !== got) begin
				errors++;
				$display("%0t: %s expected %h actual %h", $time, name, want, got);
			end
		endfunction

		function void check_result(rsp_t got);
			rsp_t want;
			if (expected_placements.size() == 0) begin
				errors++;
				$display("%0t: unexpected result expected none actual %h", $time, got);
				return;
			end
			want = expected_placements.pop_front();
			results_checked++;
			report_field("page_index", want.page_index, got.page_index);
			report_field("pos_x", want.pos_x, got.pos_x);
			report_field("pos_y", want.pos_y, got.pos_y);
			report_field("stored_offset_x", want.stored_offset_x, got.stored_offset_x);
			report_field("stored_offset_y", want.stored_offset_y, got.stored_offset_y);
			report_field("stored_height", 16'(want.stored_height), 16'(got.stored_height));
			report_field("status", 16'(want.status), 16'(got.status));
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_stall;
	req_t        req = '0;
	logic        rsp_valid;
	logic        rsp_stall = 1'b0;
	rsp_t        rsp;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = REG_TEXTURE_WIDTH;
	logic [15:0] cfg_wdata = '0;
	int unsigned cycle_count = 0;

	placement_scoreboard sb = new();

	glyph_atlas_shelf_allocator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always #6 clk = ~clk;

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Check every accepted result
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			sb.check_result(rsp);
	end

	// Stall the result side in random runs, with one long hold-off
	initial begin : receiver
		int unsigned span;
		bit          stalled, held;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!held && sb.results_checked >= HOLD_AFTER) begin
				held = 1'b1;
				stalled = 1'b1;
				span = HOLD_CYCLES;
			end else begin
				stalled = ($urandom_range(0, 2) == 0);
				if (stalled)
					span = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
						: $urandom_range(1, 3);
				else
					span = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
						: $urandom_range(1, 20);
			end
			rsp_stall <= stalled;
			repeat (span) @(posedge clk);
		end
	end

	// Offer one item, hold it until accepted, then idle for a random gap
	task automatic send_request(input req_t r);
		int unsigned gap, roll;
		req <= r;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		sb.note_request(r);
		roll = $urandom_range(0, 99);
		if (roll < 50) gap = 0;
		else if (roll < 90) gap = $urandom_range(1, 3);
		else if (roll < 98) gap = $urandom_range(4, 15);
		else gap = $urandom_range(30, 80);
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Drop the offer and hold until every expected result has come
	task automatic wait_drained();
		req_valid <= 1'b0;
		while (sb.expected_placements.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Write all three registers back to back while the block is idle
	task automatic apply_settings(input int unsigned w, input int unsigned h,
			input int unsigned g);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_index <= REG_TEXTURE_WIDTH;
		cfg_wdata <= 16'(w);
		@(posedge clk);
		cfg_index <= REG_TEXTURE_HEIGHT;
		cfg_wdata <= 16'(h);
		@(posedge clk);
		cfg_index <= REG_GLYPH_GAP;
		cfg_wdata <= 16'(g);
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.configure(w, h, g);
	endtask

	function automatic req_t build_request(int unsigned cp, int unsigned font, int ox, int oy,
			int unsigned bw, int unsigned bh, int unsigned border, int unsigned alpha);
		req_t r;
		r.code_point = 21'(cp);
		r.font_id = 8'(font);
		r.offset_x = 16'(ox);
		r.offset_y = 16'(oy);
		r.box_width = 8'(bw);
		r.box_height = 8'(bh);
		r.border_width = 8'(border);
		r.border_alpha = 8'(alpha);
		return r;
	endfunction

	// Random request: a fresh key, a placed key again, or a placed key with one bit flipped
	function automatic req_t make_request(key_kind_t kind);
		req_t        r;
		logic [44:0] k;
		int unsigned b;
		r.code_point = 21'($urandom_range(0, CODE_POINT_MAX));
		r.font_id = 8'($urandom);
		r.offset_x = 16'($urandom);
		r.offset_y = 16'($urandom);
		r.box_width = 8'($urandom_range(0, ($urandom_range(0, 4) == 0) ? 255 : 40));
		r.box_height = 8'($urandom_range(0, ($urandom_range(0, 4) == 0) ? 255 : 40));
		r.border_width = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
		r.border_alpha = 8'($urandom);
		if (kind != KEY_FRESH && sb.fill != 0) begin
			k = sb.placed_keys[$urandom_range(0, sb.fill - 1)];
			// keep the code point in range: flip only its low 16 bits or the upper key parts
			if (kind == KEY_NEAR) begin
				b = $urandom_range(0, 39);
				if (b >= 16) b += 5;
				k[b] = ~k[b];
			end
			{r.border_alpha, r.border_width, r.font_id, r.code_point} = k;
		end
		return r;
	endfunction

	initial begin : stimulus
		int unsigned phase_w [6] = '{256, 1, 65535, 65535, 300, 0};
		int unsigned phase_h [6] = '{192, 1, 65535, 65535, 4096, 0};
		int unsigned phase_g [6] = '{2, 0, 65535, 0, 3, 0};
		int unsigned roll;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: first page, repeat key, field extremes, row wrap and page change
		send_request(build_request(0, 0, 0, 0, 0, 0, 0, 0));
		send_request(build_request(0, 0, 5, -5, 30, 30, 0, 0));
		send_request(build_request(CODE_POINT_MAX, 255, -32768, 32767, 255, 255, 255, 255));
		send_request(build_request(983040, 128, 32767, -32768, 255, 255, 0, 0));
		for (int i = 0; i < 12; i++)
			send_request(build_request(1000 + i, 7, i, -i, 255, 255, 0, 1));
		send_request(build_request(CODE_POINT_MAX, 255, 1, 1, 1, 1, 255, 255));
		send_request(build_request(CODE_POINT_MAX, 255, 0, 0, 10, 10, 255, 254));
		send_request(build_request(65535, 0, 0, 0, 0, 255, 255, 0));

		// Random phases, each under its own page geometry
		phase_w[5] = $urandom_range(16, 2048);
		phase_h[5] = $urandom_range(16, 2048);
		phase_g[5] = $urandom_range(0, 8);
		for (int p = 0; p < 6; p++) begin
			apply_settings(phase_w[p], phase_h[p], phase_g[p]);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (n == PHASE_ITEMS / 2)
					wait_drained();
				roll = $urandom_range(0, 99);
				send_request(make_request((roll < 40) ? KEY_REPEAT
					: (roll < 55) ? KEY_NEAR : KEY_FRESH));
			end
		end
		req_valid <= 1'b0;

		wait_drained();
		repeat (16) @(posedge clk);
		if (sb.errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
